// ===== rtl/tcw_pkg.sv =====
// Shared types and character constants for the text console writer.
`default_nettype none

package tcw_pkg;

  // Command codes carried by each input beat.
  typedef enum logic [1:0] {
    CMD_WRITE      = 2'd0,
    CMD_SET_CURSOR = 2'd1,
    CMD_CLEAR      = 2'd2,
    CMD_READ       = 2'd3
  } cmd_e;

  // Character codes with special meaning.
  localparam logic [7:0] SPACE_CODE     = 8'h20;
  localparam logic [7:0] LAST_PRINTABLE = 8'h7f;
  localparam logic [7:0] CODE_NEWLINE   = 8'h0a;
  localparam logic [7:0] CODE_TAB       = 8'h09;
  localparam logic [7:0] CODE_BACKSPACE = 8'h08;

  // One command beat.
  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  char_code;
    logic [6:0]  new_col;
    logic [4:0]  new_row;
    logic [10:0] cell_addr;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_addr;
    logic [7:0]  cell_data;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int Width = 8,
  parameter int Depth = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_console_writer_core.sv =====
// Text console writer: character store in a RAM, cursor logic and command sequencer.
// Each command is taken in idle and passes through ST_RESP, where its result is
// registered; a scrolling write first goes through ST_SCROLL, a clear through ST_FILL.
// A new command is accepted only once the sequencer is back in idle. After reset the
// store is swept to spaces with busy high; no result is produced for that sweep.
`default_nettype none

module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire tcw_pkg::req_t req_i,
  output logic               done_o,
  output tcw_pkg::rsp_t      rsp_o
);

  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int LW    = (AW > 11) ? AW : 11;
  localparam int RW    = (CW > 11) ? CW : 11;

  localparam logic [CW-1:0] CELLS_C     = CW'(CELLS);
  localparam logic [CW-1:0] CELL_LAST_C = CW'(CELLS - 1);
  localparam logic [CW-1:0] COPY_LEN_C  = CW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] COLS_CW     = CW'(COLUMNS);
  localparam logic [7:0]    COLS_C      = 8'(COLUMNS);
  localparam logic [6:0]    COL_LAST_C  = 7'(COLUMNS - 1);
  localparam logic [4:0]    ROW_LAST_C  = 5'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_FILL,
    ST_SCROLL
  } state_e;

  state_e        state_q;
  logic [CW-1:0] sweep_q;
  logic          fill_reply_q;
  logic          bs_q;
  logic          rd_q;
  logic [6:0]    cur_col_q;
  logic [4:0]    cur_row_q;
  logic          done_q;
  rsp_t          rsp_q;

  logic          accept;
  logic [LW-1:0] cur_lin;
  logic          printable;
  logic          in_range;

  // Cursor after a write command.
  logic [7:0]    col_inc;
  logic [7:0]    tab_col;
  logic          need_nl;
  logic          need_scroll;
  logic          is_bs;
  logic [6:0]    wr_col;
  logic [4:0]    wr_row;

  // RAM controls.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign accept    = start && (state_q == ST_IDLE);
  assign busy      = (state_q != ST_IDLE);
  assign cur_lin   = LW'(LW'(cur_row_q) * LW'(COLUMNS) + LW'(cur_col_q));
  assign printable = req_i.char_code inside {[SPACE_CODE:LAST_PRINTABLE]};
  assign in_range  = RW'(req_i.cell_addr) < RW'(CELLS);

  // Next cursor for a character write: newline, tab, backspace or printable byte.
  always_comb begin
    col_inc     = {1'b0, cur_col_q} + 8'd1;
    tab_col     = {({1'b0, cur_col_q[6:3]} + 5'd1), 3'b000};
    need_nl     = 1'b0;
    is_bs       = 1'b0;
    wr_col      = cur_col_q;
    wr_row      = cur_row_q;
    if (req_i.char_code == CODE_NEWLINE) begin
      need_nl = 1'b1;
    end else if (req_i.char_code == CODE_TAB) begin
      if (tab_col >= COLS_C) begin
        need_nl = 1'b1;
      end else begin
        wr_col = tab_col[6:0];
      end
    end else if (req_i.char_code == CODE_BACKSPACE) begin
      is_bs = 1'b1;
      if (cur_col_q == 7'd0) begin
        if (cur_row_q != 5'd0) begin
          wr_col = COL_LAST_C;
          wr_row = cur_row_q - 5'd1;
        end
      end else begin
        wr_col = cur_col_q - 7'd1;
      end
    end else if (printable) begin
      if (col_inc >= COLS_C) begin
        need_nl = 1'b1;
      end else begin
        wr_col = col_inc[6:0];
      end
    end
    need_scroll = 1'b0;
    if (need_nl) begin
      wr_col = 7'd0;
      if (cur_row_q == ROW_LAST_C) begin
        need_scroll = 1'b1;
      end else begin
        wr_row = cur_row_q + 5'd1;
      end
    end
  end

  // RAM port steering for each state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(cur_lin);
    ram_wdata = req_i.char_code;
    ram_re    = 1'b0;
    ram_raddr = AW'(req_i.cell_addr);
    case (state_q)
      ST_IDLE: begin
        if (accept && req_i.cmd == CMD_WRITE && printable) begin
          ram_we = 1'b1;
        end
        if (accept && req_i.cmd == CMD_READ && in_range) begin
          ram_re = 1'b1;
        end
      end
      ST_RESP: begin
        ram_we    = bs_q;
        ram_wdata = SPACE_CODE;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(sweep_q);
        ram_wdata = SPACE_CODE;
      end
      ST_SCROLL: begin
        // Read one row ahead, write the beat read in the previous cycle.
        ram_re    = sweep_q < COPY_LEN_C;
        ram_raddr = AW'(sweep_q + COLS_CW);
        ram_we    = sweep_q != '0;
        ram_waddr = AW'(sweep_q - CW'(1));
        ram_wdata = (sweep_q <= COPY_LEN_C) ? ram_rdata : SPACE_CODE;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, cursor and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FILL;
      sweep_q      <= '0;
      fill_reply_q <= 1'b0;
      bs_q         <= 1'b0;
      rd_q         <= 1'b0;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      done_q       <= 1'b0;
      rsp_q        <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            case (req_i.cmd)
              CMD_WRITE: begin
                cur_col_q <= wr_col;
                cur_row_q <= wr_row;
                bs_q      <= is_bs;
                sweep_q   <= '0;
                state_q   <= need_scroll ? ST_SCROLL : ST_RESP;
              end
              CMD_SET_CURSOR: begin
                cur_col_q <= (req_i.new_col > COL_LAST_C) ? COL_LAST_C : req_i.new_col;
                cur_row_q <= (req_i.new_row > ROW_LAST_C) ? ROW_LAST_C : req_i.new_row;
                state_q   <= ST_RESP;
              end
              CMD_CLEAR: begin
                cur_col_q    <= '0;
                cur_row_q    <= '0;
                sweep_q      <= '0;
                fill_reply_q <= 1'b1;
                state_q      <= ST_FILL;
              end
              CMD_READ: begin
                rd_q    <= in_range;
                state_q <= ST_RESP;
              end
              default: begin
                state_q <= ST_RESP;
              end
            endcase
          end
        end
        ST_RESP: begin
          rsp_q.cursor_col  <= cur_col_q;
          rsp_q.cursor_row  <= cur_row_q;
          rsp_q.cursor_addr <= cur_lin[10:0];
          rsp_q.cell_data   <= rd_q ? ram_rdata : 8'h00;
          done_q            <= 1'b1;
          bs_q              <= 1'b0;
          rd_q              <= 1'b0;
          state_q           <= ST_IDLE;
        end
        ST_FILL: begin
          sweep_q <= sweep_q + CW'(1);
          if (sweep_q == CELL_LAST_C) begin
            fill_reply_q <= 1'b0;
            state_q      <= fill_reply_q ? ST_RESP : ST_IDLE;
          end
        end
        ST_SCROLL: begin
          sweep_q <= sweep_q + CW'(1);
          if (sweep_q == CELLS_C) begin
            state_q <= ST_RESP;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  tcw_ram #(
    .Width (8),
    .Depth (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  // A result beat is only issued as the sequencer returns to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  // An accepted command always occupies the sequencer in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted command did not raise busy");

  // The cursor never leaves the screen.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_col_q <= COL_LAST_C) && (cur_row_q <= ROW_LAST_C))
    else $error("cursor outside the screen");

  // Store writes stay inside the character store.
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) < CELLS_C))
    else $error("store write beyond last cell");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_console_pkg.sv =====
// Scoreboard for the text console writer: screen and cursor predictor and result checker.
package tb_console_pkg;

  import tcw_pkg::*;

  localparam int unsigned SCREEN_COLS  = 80;
  localparam int unsigned SCREEN_ROWS  = 25;
  localparam int unsigned SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned TAB_WIDTH    = 8;

  class console_checker;
    logic [7:0]  screen [SCREEN_CELLS];
    int unsigned col;
    int unsigned row;
    rsp_t        awaited_q [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      blank_screen();
    endfunction

    // Every cell to space and the cursor home, as after reset or a clear.
    function void blank_screen();
      foreach (screen[i]) screen[i] = SPACE_CODE;
      col = 0;
      row = 0;
    endfunction

    // Drop the top row and blank the bottom one.
    function void shift_rows_up();
      for (int unsigned i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
        screen[i] = screen[i + SCREEN_COLS];
      for (int unsigned i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
        screen[i] = SPACE_CODE;
    endfunction

    function void line_feed();
      col = 0;
      if (row + 1 >= SCREEN_ROWS) begin
        row = SCREEN_ROWS - 1;
        shift_rows_up();
      end else begin
        row++;
      end
    endfunction

    // Effect of one character byte on the screen and cursor.
    function void put_char(logic [7:0] code);
      if (code == CODE_NEWLINE) begin
        line_feed();
      end else if (code == CODE_TAB) begin
        col += TAB_WIDTH - (col % TAB_WIDTH);
        if (col >= SCREEN_COLS) line_feed();
      end else if (code == CODE_BACKSPACE) begin
        // At column 0 the cursor goes to the end of the row above, unless at home.
        if (col == 0) begin
          if (row > 0) begin
            col = SCREEN_COLS - 1;
            row--;
          end
        end else begin
          col--;
        end
        screen[row * SCREEN_COLS + col] = SPACE_CODE;
      end else if (code >= SPACE_CODE && code <= LAST_PRINTABLE) begin
        screen[row * SCREEN_COLS + col] = code;
        col++;
        if (col >= SCREEN_COLS) line_feed();
      end
    endfunction

    // Apply one accepted command beat and queue the result it must give.
    function void note_command(req_t r);
      rsp_t want;
      want.cell_data = '0;
      case (r.cmd)
        CMD_WRITE: put_char(r.char_code);
        CMD_SET_CURSOR: begin
          col = (r.new_col >= SCREEN_COLS) ? SCREEN_COLS - 1 : r.new_col;
          row = (r.new_row >= SCREEN_ROWS) ? SCREEN_ROWS - 1 : r.new_row;
        end
        CMD_CLEAR: blank_screen();
        CMD_READ: if (r.cell_addr < SCREEN_CELLS) want.cell_data = screen[r.cell_addr];
        default: ;
      endcase
      want.cursor_col  = 7'(col);
      want.cursor_row  = 5'(row);
      want.cursor_addr = 11'(row * SCREEN_COLS + col);
      awaited_q.push_back(want);
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endfunction

    // Compare a result beat with the oldest expectation, field by field.
    function void check_result(rsp_t got);
      rsp_t want;
      if (awaited_q.size() == 0) begin
        report($sformatf("result beat with nothing outstanding: %h", got));
        return;
      end
      want = awaited_q.pop_front();
      if (got.cursor_col !== want.cursor_col)
        report($sformatf("cursor_col %0d, expected %0d", got.cursor_col, want.cursor_col));
      if (got.cursor_row !== want.cursor_row)
        report($sformatf("cursor_row %0d, expected %0d", got.cursor_row, want.cursor_row));
      if (got.cursor_addr !== want.cursor_addr)
        report($sformatf("cursor_addr %0d, expected %0d",
                         got.cursor_addr, want.cursor_addr));
      if (got.cell_data !== want.cell_data)
        report($sformatf("cell_data %h, expected %h", got.cell_data, want.cell_data));
    endfunction

    function int unsigned outstanding();
      return awaited_q.size();
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for the text console writer core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;
  import tb_console_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1750;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned SETTLE_WAIT  = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic done_o;
  rsp_t rsp_o;

  console_checker sb;
  bit             gaps_on = 1'b1;
  int unsigned    stall_count = 0;

  text_console_writer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Every result beat is taken at the edge that ends its strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_result(rsp_o);
  end

  // Give up when no command beat has been accepted for too long.
  always @(posedge clk_i) begin
    if (rst_ni && start && busy === 1'b0) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic req_t make_beat(cmd_e c, logic [7:0] code, logic [6:0] ncol,
                                     logic [4:0] nrow, logic [10:0] addr);
    req_t r;
    r.cmd       = c;
    r.char_code = code;
    r.new_col   = ncol;
    r.new_row   = nrow;
    r.cell_addr = addr;
    return r;
  endfunction

  // Mostly character writes; reads often land just behind the cursor to read back text.
  function automatic req_t random_beat();
    req_t        r;
    int unsigned pick;
    int          near;
    r = make_beat(CMD_WRITE, 8'($urandom), 7'($urandom), 5'($urandom), 11'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      pick = $urandom_range(0, 99);
      if (pick < 62)      r.char_code = 8'($urandom_range(SPACE_CODE, LAST_PRINTABLE));
      else if (pick < 70) r.char_code = CODE_NEWLINE;
      else if (pick < 77) r.char_code = CODE_TAB;
      else if (pick < 87) r.char_code = CODE_BACKSPACE;
    end else if (pick < 82) begin
      r.cmd = CMD_SET_CURSOR;
      if ($urandom_range(0, 1) != 0) r.new_col = 7'($urandom_range(0, SCREEN_COLS - 1));
      if ($urandom_range(0, 1) != 0) r.new_row = 5'($urandom_range(0, SCREEN_ROWS - 1));
    end else if (pick < 98) begin
      r.cmd = CMD_READ;
      if ($urandom_range(0, 1) != 0) begin
        near = int'(sb.row * SCREEN_COLS + sb.col) - int'($urandom_range(0, 15));
        r.cell_addr = 11'((near < 0) ? 0 : near);
      end
    end else begin
      r.cmd = CMD_CLEAR;
    end
    return r;
  endfunction

  // Present one command beat after a random gap and wait until it is taken.
  task automatic send_beat(input req_t r);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_command(r);
  endtask

  // Hold off new commands until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    req_t directed_q [$];
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats: byte extremes, control codes, wraps, scrolls, reads and a clear.
    directed_q.push_back(make_beat(CMD_WRITE, SPACE_CODE, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_WRITE, LAST_PRINTABLE, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_WRITE, 8'h00, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_WRITE, 8'hff, '1, '1, '1));
    directed_q.push_back(make_beat(CMD_WRITE, 8'h80, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_WRITE, CODE_BACKSPACE, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_WRITE, CODE_TAB, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_WRITE, CODE_NEWLINE, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_WRITE, CODE_BACKSPACE, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_SET_CURSOR, '0, 7'd0, 5'd0, '0));
    directed_q.push_back(make_beat(CMD_WRITE, CODE_BACKSPACE, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_SET_CURSOR, '0, 7'd79, 5'd23, '0));
    directed_q.push_back(make_beat(CMD_WRITE, 8'h5a, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_SET_CURSOR, '0, 7'd127, 5'd31, '0));
    directed_q.push_back(make_beat(CMD_WRITE, 8'h41, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_SET_CURSOR, '0, 7'd75, 5'd24, '0));
    directed_q.push_back(make_beat(CMD_WRITE, CODE_TAB, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_WRITE, CODE_NEWLINE, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_READ, '0, '0, '0, 11'd0));
    directed_q.push_back(make_beat(CMD_READ, '0, '0, '0, 11'd1999));
    directed_q.push_back(make_beat(CMD_READ, '0, '0, '0, 11'd1840));
    directed_q.push_back(make_beat(CMD_READ, '0, '0, '0, 11'd2000));
    directed_q.push_back(make_beat(CMD_READ, '1, '1, '1, 11'd2047));
    directed_q.push_back(make_beat(CMD_CLEAR, '0, '0, '0, '0));
    directed_q.push_back(make_beat(CMD_READ, '0, '0, '0, 11'd1840));
    foreach (directed_q[i]) send_beat(directed_q[i]);
    drain();

    // Random beats, with runs free of gaps and an occasional full drain.
    for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) == 0) drain();
      send_beat(random_beat());
    end
    start <= 1'b0;

    // Let the last results arrive, then idle for a settling wait.
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d results never arrived", sb.outstanding()));
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer_core.sv
tb/tb_console_pkg.sv
tb/tb_top.sv
